// ----- src/r4fft_pkg.sv -----
// Shared constants and pipeline control types for the radix-4 FFT butterfly unit.
package r4fft_pkg;

    // Default sample width and twiddle fraction width.
    localparam int SAMPLE_WIDTH_DEF      = 24;
    localparam int TWIDDLE_FRAC_BITS_DEF = 16;

    // Register stages of the butterfly pipeline, in order.
    localparam int NUM_STAGES = 6;
    localparam int ST_MUL_W2  = 0;  // products of w2 with x2 and x3
    localparam int ST_RND_W2  = 1;  // combine, round and clip the w2 products
    localparam int ST_BFLY_1  = 2;  // a, b, c, d
    localparam int ST_MUL_W1  = 3;  // products of w1 with c and d
    localparam int ST_RND_W1  = 4;  // combine, round and clip the w1 products
    localparam int ST_BFLY_2  = 5;  // y0..y3, also the output register

    // Control from the valid/ready chain to the datapath.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;      // stage register takes a new item
        logic                  in_ready;  // first stage can take an item
        logic                  out_valid; // last stage holds an item
    } r4fft_pipe_ctrl_t;

endpackage

// ----- src/radix4_fft_butterfly_unit.sv -----
// Radix-4 decimation-in-time FFT butterfly, six-stage pipeline, top level.
//
// Use: each item on the slave stream carries four complex samples x0..x3 and
// two complex Q2.16 twiddles w1 and w2. Each accepted item gives exactly one
// item on the master stream holding y0..y3 of one radix-4 butterfly, with every
// complex product rounded to nearest and every output saturated to 27 bits.
// Items leave in the order they arrived.
// Pipeline: six register stages, in order w2 products, w2 rounding, the first
// add/subtract layer, w1 products, w1 rounding and the final add/subtract
// layer, which is also the output register.
// Throughput: one item per cycle while the master side accepts; each product
// stage has its own pair of complex multipliers.
// Stall: every stage holds its own valid bit and loads whenever it is empty or
// its item moves on, so while the master side stalls, items keep entering
// until all six stages are full; then s_axis_tready falls. Nothing is dropped
// or repeated.
// Reset: aresetn low at a clock edge empties the pipeline; items in flight
// are discarded and m_axis_tvalid is low afterwards.
module radix4_fft_butterfly_unit #(
    parameter int SAMPLE_WIDTH      = r4fft_pkg::SAMPLE_WIDTH_DEF,
    parameter int TWIDDLE_FRAC_BITS = r4fft_pkg::TWIDDLE_FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // x0_re, x0_im, x1_re, x1_im, x2_re, x2_im, x3_re, x3_im, w1_re, w1_im,
    // w2_re, w2_im from the lowest bit up, zero padded to whole bytes.
    input  logic [((8*SAMPLE_WIDTH+4*(TWIDDLE_FRAC_BITS+2)+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // y0_re, y0_im, y1_re, y1_im, y2_re, y2_im, y3_re, y3_im from the lowest
    // bit up, zero padded to whole bytes.
    output logic [((8*(SAMPLE_WIDTH+3)+7)/8)*8-1:0] m_axis_tdata
);

    import r4fft_pkg::*;

    localparam int SW      = SAMPLE_WIDTH;
    localparam int TW      = TWIDDLE_FRAC_BITS + 2;
    localparam int OW      = SAMPLE_WIDTH + 3;
    localparam int PW      = OW + 2;
    localparam int OUT_TDW = ((8*OW+7)/8)*8;
    localparam int W_BASE  = 8*SW;

    r4fft_pipe_ctrl_t ctrl;

    logic signed [SW-1:0] x_in [8];
    logic signed [TW-1:0] w1_re, w1_im, w2_re, w2_im;

    logic signed [SW-1:0] x01_d_reg [2][4];   // x0_re, x0_im, x1_re, x1_im
    logic signed [TW-1:0] w1_d_reg [3][2];    // w1_re, w1_im
    logic signed [OW-1:0] ab_d_reg [2][4];    // ar, ai, br, bi

    logic signed [PW-1:0] p2_re, p2_im, p3_re, p3_im;
    logic signed [OW-1:0] ar, ai, br, bi, cr, ci, dr, di;
    logic signed [PW-1:0] pc_re, pc_im, pd_re, pd_im;
    logic signed [OW-1:0] y0_re, y0_im, y1_re, y1_im, y2_re, y2_im, y3_re, y3_im;
    logic [8*OW-1:0]      y_packed;

    for (genvar i = 0; i < 8; i++) begin : g_unpack
        assign x_in[i] = s_axis_tdata[i*SW +: SW];
    end

    assign w1_re = s_axis_tdata[W_BASE        +: TW];
    assign w1_im = s_axis_tdata[W_BASE + TW   +: TW];
    assign w2_re = s_axis_tdata[W_BASE + 2*TW +: TW];
    assign w2_im = s_axis_tdata[W_BASE + 3*TW +: TW];

    r4fft_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .m_ready (m_axis_tready),
        .ctrl    (ctrl)
    );

    assign s_axis_tready = ctrl.in_ready;
    assign m_axis_tvalid = ctrl.out_valid;

    // Operands that bypass the multipliers travel alongside them.
    always_ff @(posedge aclk) begin
        if (ctrl.load[ST_MUL_W2]) begin
            x01_d_reg[0] <= '{x_in[0], x_in[1], x_in[2], x_in[3]};
            w1_d_reg[0]  <= '{w1_re, w1_im};
        end
        if (ctrl.load[ST_RND_W2]) begin
            x01_d_reg[1] <= x01_d_reg[0];
            w1_d_reg[1]  <= w1_d_reg[0];
        end
        if (ctrl.load[ST_BFLY_1]) begin
            w1_d_reg[2] <= w1_d_reg[1];
        end
        if (ctrl.load[ST_MUL_W1]) begin
            ab_d_reg[0] <= '{ar, ai, br, bi};
        end
        if (ctrl.load[ST_RND_W1]) begin
            ab_d_reg[1] <= ab_d_reg[0];
        end
    end

    // w2 * x2 and w2 * x3.
    r4fft_cmul #(
        .X_WIDTH (SW), .TW_WIDTH (TW), .FRAC_BITS (TWIDDLE_FRAC_BITS), .RES_WIDTH (PW)
    ) u_cmul_x2 (
        .aclk     (aclk),
        .load_mul (ctrl.load[ST_MUL_W2]),
        .load_rnd (ctrl.load[ST_RND_W2]),
        .x_re     (x_in[4]),
        .x_im     (x_in[5]),
        .w_re     (w2_re),
        .w_im     (w2_im),
        .p_re     (p2_re),
        .p_im     (p2_im)
    );

    r4fft_cmul #(
        .X_WIDTH (SW), .TW_WIDTH (TW), .FRAC_BITS (TWIDDLE_FRAC_BITS), .RES_WIDTH (PW)
    ) u_cmul_x3 (
        .aclk     (aclk),
        .load_mul (ctrl.load[ST_MUL_W2]),
        .load_rnd (ctrl.load[ST_RND_W2]),
        .x_re     (x_in[6]),
        .x_im     (x_in[7]),
        .w_re     (w2_re),
        .w_im     (w2_im),
        .p_re     (p3_re),
        .p_im     (p3_im)
    );

    // a = x0 + w2*x2, b = x0 - w2*x2, c = x1 + w2*x3, d = x1 - w2*x3.
    r4fft_addsub #(.U_WIDTH(SW), .P_WIDTH(PW), .OUT_WIDTH(OW)) u_ab_re (
        .aclk (aclk), .load (ctrl.load[ST_BFLY_1]),
        .u (x01_d_reg[1][0]), .p (p2_re), .sum_out (ar), .dif_out (br)
    );

    r4fft_addsub #(.U_WIDTH(SW), .P_WIDTH(PW), .OUT_WIDTH(OW)) u_ab_im (
        .aclk (aclk), .load (ctrl.load[ST_BFLY_1]),
        .u (x01_d_reg[1][1]), .p (p2_im), .sum_out (ai), .dif_out (bi)
    );

    r4fft_addsub #(.U_WIDTH(SW), .P_WIDTH(PW), .OUT_WIDTH(OW)) u_cd_re (
        .aclk (aclk), .load (ctrl.load[ST_BFLY_1]),
        .u (x01_d_reg[1][2]), .p (p3_re), .sum_out (cr), .dif_out (dr)
    );

    r4fft_addsub #(.U_WIDTH(SW), .P_WIDTH(PW), .OUT_WIDTH(OW)) u_cd_im (
        .aclk (aclk), .load (ctrl.load[ST_BFLY_1]),
        .u (x01_d_reg[1][3]), .p (p3_im), .sum_out (ci), .dif_out (di)
    );

    // w1 * c and w1 * d.
    r4fft_cmul #(
        .X_WIDTH (OW), .TW_WIDTH (TW), .FRAC_BITS (TWIDDLE_FRAC_BITS), .RES_WIDTH (PW)
    ) u_cmul_c (
        .aclk     (aclk),
        .load_mul (ctrl.load[ST_MUL_W1]),
        .load_rnd (ctrl.load[ST_RND_W1]),
        .x_re     (cr),
        .x_im     (ci),
        .w_re     (w1_d_reg[2][0]),
        .w_im     (w1_d_reg[2][1]),
        .p_re     (pc_re),
        .p_im     (pc_im)
    );

    r4fft_cmul #(
        .X_WIDTH (OW), .TW_WIDTH (TW), .FRAC_BITS (TWIDDLE_FRAC_BITS), .RES_WIDTH (PW)
    ) u_cmul_d (
        .aclk     (aclk),
        .load_mul (ctrl.load[ST_MUL_W1]),
        .load_rnd (ctrl.load[ST_RND_W1]),
        .x_re     (dr),
        .x_im     (di),
        .w_re     (w1_d_reg[2][0]),
        .w_im     (w1_d_reg[2][1]),
        .p_re     (pd_re),
        .p_im     (pd_im)
    );

    // y0/y2 = a +/- w1*c. Since j*(w1*d) is (-im, re), y1 = b + j*w1*d and
    // y3 = b - j*w1*d take the real part of b with the imaginary product and
    // the other way round.
    r4fft_addsub #(.U_WIDTH(OW), .P_WIDTH(PW), .OUT_WIDTH(OW)) u_y02_re (
        .aclk (aclk), .load (ctrl.load[ST_BFLY_2]),
        .u (ab_d_reg[1][0]), .p (pc_re), .sum_out (y0_re), .dif_out (y2_re)
    );

    r4fft_addsub #(.U_WIDTH(OW), .P_WIDTH(PW), .OUT_WIDTH(OW)) u_y02_im (
        .aclk (aclk), .load (ctrl.load[ST_BFLY_2]),
        .u (ab_d_reg[1][1]), .p (pc_im), .sum_out (y0_im), .dif_out (y2_im)
    );

    r4fft_addsub #(.U_WIDTH(OW), .P_WIDTH(PW), .OUT_WIDTH(OW)) u_y13_re (
        .aclk (aclk), .load (ctrl.load[ST_BFLY_2]),
        .u (ab_d_reg[1][2]), .p (pd_im), .sum_out (y3_re), .dif_out (y1_re)
    );

    r4fft_addsub #(.U_WIDTH(OW), .P_WIDTH(PW), .OUT_WIDTH(OW)) u_y13_im (
        .aclk (aclk), .load (ctrl.load[ST_BFLY_2]),
        .u (ab_d_reg[1][3]), .p (pd_re), .sum_out (y1_im), .dif_out (y3_im)
    );

    assign y_packed     = {y3_im, y3_re, y2_im, y2_re, y1_im, y1_re, y0_im, y0_re};
    assign m_axis_tdata = OUT_TDW'(y_packed);

endmodule

// ----- src/r4fft_sat.sv -----
// Signed saturation of a wide value to a narrower two's complement range.
module r4fft_sat #(
    parameter int IN_WIDTH  = 30,
    parameter int OUT_WIDTH = 27
) (
    input  logic signed [IN_WIDTH-1:0]  d,
    output logic signed [OUT_WIDTH-1:0] q
);

    localparam logic signed [OUT_WIDTH-1:0] MAX_VAL = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic signed [OUT_WIDTH-1:0] MIN_VAL = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    if (IN_WIDTH > OUT_WIDTH) begin : g_clip
        logic [IN_WIDTH-OUT_WIDTH:0] top_bits;

        assign top_bits = d[IN_WIDTH-1:OUT_WIDTH-1];

        // The value fits when every bit above the new sign bit matches it.
        always_comb begin
            if ((&top_bits) || (~|top_bits)) begin
                q = d[OUT_WIDTH-1:0];
            end else if (d[IN_WIDTH-1]) begin
                q = MIN_VAL;
            end else begin
                q = MAX_VAL;
            end
        end
    end else begin : g_extend
        assign q = OUT_WIDTH'(d);
    end

endmodule

// ----- src/r4fft_cmul.sv -----
// Two-stage complex multiplier with round-to-nearest, shift and saturation.
module r4fft_cmul #(
    parameter int X_WIDTH   = 24,
    parameter int TW_WIDTH  = 18,
    parameter int FRAC_BITS = 16,
    parameter int RES_WIDTH = 29
) (
    input  logic                        aclk,
    input  logic                        load_mul,
    input  logic                        load_rnd,
    input  logic signed [X_WIDTH-1:0]   x_re,
    input  logic signed [X_WIDTH-1:0]   x_im,
    input  logic signed [TW_WIDTH-1:0]  w_re,
    input  logic signed [TW_WIDTH-1:0]  w_im,
    output logic signed [RES_WIDTH-1:0] p_re,
    output logic signed [RES_WIDTH-1:0] p_im
);

    localparam int PROD_WIDTH  = X_WIDTH + TW_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 1;
    localparam int SHIFT_WIDTH = SUM_WIDTH - FRAC_BITS;
    localparam logic signed [SUM_WIDTH-1:0] RND_HALF =
        {{(SUM_WIDTH-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    logic signed [PROD_WIDTH-1:0]  rr_reg, ii_reg, ri_reg, ir_reg;
    logic signed [SUM_WIDTH-1:0]   re_sum, im_sum;
    logic signed [SHIFT_WIDTH-1:0] re_shift, im_shift;
    logic signed [RES_WIDTH-1:0]   re_next, im_next;
    logic signed [RES_WIDTH-1:0]   p_re_reg, p_im_reg;

    always_ff @(posedge aclk) begin
        if (load_mul) begin
            rr_reg <= PROD_WIDTH'(w_re) * PROD_WIDTH'(x_re);
            ii_reg <= PROD_WIDTH'(w_im) * PROD_WIDTH'(x_im);
            ri_reg <= PROD_WIDTH'(w_re) * PROD_WIDTH'(x_im);
            ir_reg <= PROD_WIDTH'(w_im) * PROD_WIDTH'(x_re);
        end
    end

    // Adding half an LSB before the arithmetic shift rounds ties upwards.
    assign re_sum   = SUM_WIDTH'(rr_reg) - SUM_WIDTH'(ii_reg) + RND_HALF;
    assign im_sum   = SUM_WIDTH'(ri_reg) + SUM_WIDTH'(ir_reg) + RND_HALF;
    assign re_shift = re_sum[SUM_WIDTH-1:FRAC_BITS];
    assign im_shift = im_sum[SUM_WIDTH-1:FRAC_BITS];

    r4fft_sat #(.IN_WIDTH(SHIFT_WIDTH), .OUT_WIDTH(RES_WIDTH)) u_sat_re (
        .d (re_shift),
        .q (re_next)
    );

    r4fft_sat #(.IN_WIDTH(SHIFT_WIDTH), .OUT_WIDTH(RES_WIDTH)) u_sat_im (
        .d (im_shift),
        .q (im_next)
    );

    always_ff @(posedge aclk) begin
        if (load_rnd) begin
            p_re_reg <= re_next;
            p_im_reg <= im_next;
        end
    end

    assign p_re = p_re_reg;
    assign p_im = p_im_reg;

endmodule

// ----- src/r4fft_addsub.sv -----
// Registered saturating sum and difference of one real operand pair.
module r4fft_addsub #(
    parameter int U_WIDTH   = 24,
    parameter int P_WIDTH   = 29,
    parameter int OUT_WIDTH = 27
) (
    input  logic                        aclk,
    input  logic                        load,
    input  logic signed [U_WIDTH-1:0]   u,
    input  logic signed [P_WIDTH-1:0]   p,
    output logic signed [OUT_WIDTH-1:0] sum_out,
    output logic signed [OUT_WIDTH-1:0] dif_out
);

    localparam int RAW_WIDTH = ((U_WIDTH > P_WIDTH) ? U_WIDTH : P_WIDTH) + 1;

    logic signed [RAW_WIDTH-1:0] sum_raw, dif_raw;
    logic signed [OUT_WIDTH-1:0] sum_next, dif_next;
    logic signed [OUT_WIDTH-1:0] sum_reg, dif_reg;

    assign sum_raw = RAW_WIDTH'(u) + RAW_WIDTH'(p);
    assign dif_raw = RAW_WIDTH'(u) - RAW_WIDTH'(p);

    r4fft_sat #(.IN_WIDTH(RAW_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_sat_sum (
        .d (sum_raw),
        .q (sum_next)
    );

    r4fft_sat #(.IN_WIDTH(RAW_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_sat_dif (
        .d (dif_raw),
        .q (dif_next)
    );

    always_ff @(posedge aclk) begin
        if (load) begin
            sum_reg <= sum_next;
            dif_reg <= dif_next;
        end
    end

    assign sum_out = sum_reg;
    assign dif_out = dif_reg;

endmodule

// ----- src/r4fft_pipe_ctrl.sv -----
// Valid bits and per-stage ready chain of the butterfly pipeline.
module r4fft_pipe_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        m_ready,
    output r4fft_pkg::r4fft_pipe_ctrl_t ctrl
);

    import r4fft_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg, valid_next, load, prev_valid;

    // A stage may load when it is empty or when its item moves on this cycle,
    // so bubbles close up while the output waits.
    always_comb begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign prev_valid = {valid_reg[NUM_STAGES-2:0], s_valid};
    assign valid_next = (load & prev_valid) | (~load & valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load      = load;
    assign ctrl.in_ready  = load[0];
    assign ctrl.out_valid = valid_reg[NUM_STAGES-1];

endmodule
